/* design/radio_scan_controller_macros.svh */
// Assertion macros used by the scan controller design file.
`ifndef RADIO_SCAN_CONTROLLER_MACROS_SVH
`define RADIO_SCAN_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define RSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSC_ASSERT(lbl, prop, msg)
`define RSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/rsc_pkg.sv */
// Types and constants of the radio scan controller.
package rsc_pkg;

  // Width of the dwell timer.
  localparam int unsigned TIMER_W = 8;

  // Event codes carried in the mode field.
  localparam logic [2:0] EV_POLL  = 3'd0;
  localparam logic [2:0] EV_TICK  = 3'd1;
  localparam logic [2:0] EV_START = 3'd2;
  localparam logic [2:0] EV_UP    = 3'd3;
  localparam logic [2:0] EV_DOWN  = 3'd4;
  localparam logic [2:0] EV_STOP  = 3'd5;

  // Resume mode register codes.
  localparam logic [1:0] RESUME_TIME = 2'd0;
  localparam logic [1:0] RESUME_LOST = 2'd1;
  localparam logic [1:0] RESUME_FIND = 2'd2;

  // Step commands.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  // Beep codes.
  localparam logic [2:0] BEEP_NONE = 3'd0;
  localparam logic [2:0] BEEP_ERR  = 3'd1;
  localparam logic [2:0] BEEP_UP   = 3'd2;
  localparam logic [2:0] BEEP_DOWN = 3'd3;
  localparam logic [2:0] BEEP_STOP = 3'd4;
  localparam logic [2:0] BEEP_NUL  = 3'd5;

  // Fixed dwell timer loads.
  localparam logic [TIMER_W-1:0] DWELL_STEP  = 8'd2;
  localparam logic [TIMER_W-1:0] DWELL_START = 8'd4;
  localparam logic [TIMER_W-1:0] DWELL_HOLD  = 8'd50;

  // Scan phases.
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SCANNING    = 3'd1,
    PH_WAIT_TIME   = 3'd2,
    PH_WAIT_LOST   = 3'd3,
    PH_WAIT_RECALL = 3'd4,
    PH_STOP        = 3'd5
  } phase_t;

  // One input beat.
  typedef struct packed {
    logic [2:0] mode;
    logic       squelch_open;
    logic       channel_mode;
    logic       has_scan_channels;
    logic       range_ok;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] step_cmd;
    logic       recall_pulse;
    logic [2:0] beep_code;
    logic       scan_active;
    logic [2:0] scan_state;
  } out_t;

endpackage

/* design/radio_scan_controller.sv */
// Radio scan controller: scan sequencer with a registered result stage.
// A result beat appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the result side does not stall, set by the single next-state stage.
// Reset (synchronous, rst_n low): idle, inactive, direction up, timers cleared.
// Reset also clears the resume mode to resume-after-time and empties the output.
`include "radio_scan_controller_macros.svh"

module radio_scan_controller #(
  parameter int unsigned LOST_TIME  = 20,
  parameter int unsigned FIND_TIME  = 20,
  parameter int unsigned SQ_CONFIRM = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  import rsc_pkg::*;

  localparam logic [TIMER_W-1:0] LOST_LOAD = TIMER_W'(LOST_TIME);
  localparam logic [TIMER_W-1:0] FIND_LOAD = TIMER_W'(FIND_TIME);
  localparam logic [1:0]         SQ_LIMIT  = 2'(SQ_CONFIRM);

  logic [1:0]         resume_mode_r;
  phase_t             phase_r, phase_nxt;
  logic               active_r, active_nxt;
  logic               dir_down_r, dir_down_nxt;
  logic [TIMER_W-1:0] dwell_timer_r, dwell_timer_nxt;
  logic [1:0]         squelch_count_r, squelch_count_nxt;
  logic               out_valid_r;
  out_t               out_r;

  logic               accept;
  logic               want_step;
  logic [TIMER_W-1:0] timer_pre;
  phase_t             phase_pre;
  logic [1:0]         step_cmd;
  logic               recall;
  logic [2:0]         beep;

  // A new beat enters whenever the result register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Event decode: everything except the step rule.
  always_comb begin
    phase_pre         = phase_r;
    active_nxt        = active_r;
    dir_down_nxt      = dir_down_r;
    timer_pre         = dwell_timer_r;
    squelch_count_nxt = squelch_count_r;
    want_step         = 1'b0;
    recall            = 1'b0;
    beep              = BEEP_NONE;
    unique case (in_data.mode)
      EV_POLL: begin
        if (active_r) begin
          unique case (phase_r)
            PH_SCANNING: begin
              if (in_data.squelch_open) begin
                if (squelch_count_r < SQ_LIMIT) begin
                  squelch_count_nxt = squelch_count_r + 2'd1;
                end else begin
                  unique case (resume_mode_r)
                    RESUME_TIME: begin
                      phase_pre = PH_WAIT_TIME;
                      timer_pre = LOST_LOAD;
                    end
                    RESUME_LOST: begin
                      phase_pre = PH_WAIT_LOST;
                      timer_pre = LOST_LOAD;
                    end
                    RESUME_FIND: begin
                      phase_pre = PH_STOP;
                      timer_pre = FIND_LOAD;
                    end
                    default: ;
                  endcase
                end
              end else begin
                want_step         = 1'b1;
                squelch_count_nxt = '0;
              end
            end
            PH_WAIT_TIME: begin
              if (resume_mode_r == RESUME_LOST && in_data.squelch_open) begin
                timer_pre = DWELL_HOLD;
              end
              want_step         = 1'b1;
              squelch_count_nxt = '0;
            end
            PH_WAIT_LOST: begin
              if (in_data.squelch_open) begin
                timer_pre = LOST_LOAD;
              end else if (dwell_timer_r == '0) begin
                phase_pre = PH_WAIT_RECALL;
              end
            end
            PH_WAIT_RECALL: begin
              want_step         = 1'b1;
              squelch_count_nxt = '0;
            end
            PH_STOP: begin
              phase_pre         = PH_IDLE;
              timer_pre         = '0;
              active_nxt        = 1'b0;
              recall            = 1'b1;
              squelch_count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      EV_TICK: begin
        if (dwell_timer_r != '0) begin
          timer_pre = dwell_timer_r - TIMER_W'(1);
        end
      end
      EV_START: begin
        if (active_r) begin
          beep = BEEP_NUL;
        end else if (in_data.channel_mode ? !in_data.has_scan_channels
                                          : !in_data.range_ok) begin
          beep = BEEP_ERR;
        end else begin
          // The start load keeps the step rule from firing.
          active_nxt   = 1'b1;
          phase_pre    = PH_SCANNING;
          timer_pre    = DWELL_START;
          dir_down_nxt = 1'b0;
        end
      end
      EV_UP, EV_DOWN: begin
        if (active_r) begin
          dir_down_nxt = (in_data.mode == EV_DOWN);
          beep         = (in_data.mode == EV_DOWN) ? BEEP_DOWN : BEEP_UP;
          timer_pre    = '0;
          want_step    = 1'b1;
        end
      end
      EV_STOP: begin
        if (active_r) begin
          phase_pre  = PH_IDLE;
          timer_pre  = '0;
          active_nxt = 1'b0;
          beep       = BEEP_STOP;
        end
      end
      default: begin
        if (active_r) begin
          beep = BEEP_NUL;
        end
      end
    endcase
  end

  // Step rule: step only once the dwell timer has run out.
  always_comb begin
    phase_nxt       = phase_pre;
    dwell_timer_nxt = timer_pre;
    step_cmd        = STEP_NONE;
    if (want_step && timer_pre == '0) begin
      step_cmd        = dir_down_nxt ? STEP_DOWN : STEP_UP;
      phase_nxt       = PH_SCANNING;
      dwell_timer_nxt = DWELL_STEP;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resume_mode_r <= RESUME_TIME;
    end else if (cfg_we) begin
      resume_mode_r <= cfg_wdata;
    end
  end

  // Scan state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      active_r        <= 1'b0;
      dir_down_r      <= 1'b0;
      dwell_timer_r   <= '0;
      squelch_count_r <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      active_r        <= active_nxt;
      dir_down_r      <= dir_down_nxt;
      dwell_timer_r   <= dwell_timer_nxt;
      squelch_count_r <= squelch_count_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.step_cmd     <= step_cmd;
      out_r.recall_pulse <= recall;
      out_r.beep_code    <= beep;
      out_r.scan_active  <= active_nxt;
      out_r.scan_state   <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Idle scan means idle phase and a cleared timer.
  `RSC_ASSERT(a_idle_phase, !active_r |-> (phase_r == PH_IDLE), "inactive scan not in idle phase")
  `RSC_ASSERT(a_idle_timer, !active_r |-> (dwell_timer_r == '0), "inactive scan with running timer")
  // Every accepted beat produces a result beat in the next cycle.
  `RSC_ASSERT(a_result, accept |=> out_valid_r, "accepted beat produced no result")
  // A recall always ends the scan.
  `RSC_ASSERT(a_recall_ends, (out_valid_r && out_r.recall_pulse) |-> !out_r.scan_active,
              "recall pulse while scan still active")

endmodule

/* bench/scan_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks the scan controller's result beats.
`timescale 1ns / 1ps

package scan_scoreboard_pkg;
  import rsc_pkg::*;

  // Timing parameters of the scan sequencer as instantiated on the bench.
  localparam int unsigned LOST_TIME  = 20;
  localparam int unsigned FIND_TIME  = 20;
  localparam int unsigned SQ_CONFIRM = 3;

  // Resume mode code that selects no hold behavior at all.
  localparam logic [1:0] RESUME_NONE = 2'd3;

  // Event codes that the block does not define.
  localparam logic [2:0] EV_UNDEF_A = 3'd6;
  localparam logic [2:0] EV_UNDEF_B = 3'd7;

  // Keep the log short when the design is badly broken.
  localparam int unsigned PRINT_LIMIT = 200;

  class scan_scoreboard;
    logic [1:0]  resume_mode;
    phase_t      phase;
    bit          active;
    bit          dir_down;
    logic [7:0]  dwell;
    logic [1:0]  sq_count;
    out_t        result;
    out_t        expected_q[$];
    int unsigned failures;

    // Predictor state matches the block right after reset.
    function new();
      resume_mode = RESUME_TIME;
      phase       = PH_IDLE;
      active      = 1'b0;
      dir_down    = 1'b0;
      dwell       = '0;
      sq_count    = '0;
      failures    = 0;
    endfunction

    function void set_resume(logic [1:0] value);
      resume_mode = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Prints one line per mismatch, up to the print limit, and counts every one.
    task report(string what, int got, int want);
      if (failures < PRINT_LIMIT) begin
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      end
      failures++;
    endtask

    // Steps in the current direction once the dwell timer has run out.
    function void take_step();
      if (dwell != '0) begin
        return;
      end
      result.step_cmd = dir_down ? STEP_DOWN : STEP_UP;
      phase = PH_SCANNING;
      dwell = DWELL_STEP;
    endfunction

    function void end_scan();
      phase  = PH_IDLE;
      dwell  = '0;
      active = 1'b0;
    endfunction

    // Works out the result of one accepted input beat and queues it.
    function void note_beat(in_t beat);
      bit sq;
      sq = beat.squelch_open;
      result = '0;
      case (beat.mode)
        EV_POLL: begin
          if (active) begin
            case (phase)
              PH_SCANNING: begin
                if (sq) begin
                  // Squelch has to stay open for several polls before the scan holds.
                  if (sq_count < 2'(SQ_CONFIRM)) begin
                    sq_count = sq_count + 2'd1;
                  end else if (resume_mode == RESUME_TIME) begin
                    phase = PH_WAIT_TIME;
                    dwell = 8'(LOST_TIME);
                  end else if (resume_mode == RESUME_LOST) begin
                    phase = PH_WAIT_LOST;
                    dwell = 8'(LOST_TIME);
                  end else if (resume_mode == RESUME_FIND) begin
                    phase = PH_STOP;
                    dwell = 8'(FIND_TIME);
                  end
                end else begin
                  take_step();
                  sq_count = '0;
                end
              end
              PH_WAIT_TIME: begin
                // A carrier in carrier-lost mode pushes the timer out to the long hold.
                if (resume_mode == RESUME_LOST && sq) begin
                  dwell = DWELL_HOLD;
                end
                take_step();
                sq_count = '0;
              end
              PH_WAIT_LOST: begin
                if (!sq) begin
                  if (dwell == '0) begin
                    phase = PH_WAIT_RECALL;
                  end
                end else begin
                  dwell = 8'(LOST_TIME);
                end
              end
              PH_WAIT_RECALL: begin
                take_step();
                sq_count = '0;
              end
              PH_STOP: begin
                end_scan();
                result.recall_pulse = 1'b1;
                sq_count = '0;
              end
              default: ;
            endcase
          end
        end
        EV_TICK: begin
          if (dwell != '0) begin
            dwell = dwell - 8'd1;
          end
        end
        EV_START: begin
          if (active) begin
            result.beep_code = BEEP_NUL;
          end else if (beat.channel_mode ? !beat.has_scan_channels : !beat.range_ok) begin
            result.beep_code = BEEP_ERR;
          end else begin
            active   = 1'b1;
            phase    = PH_SCANNING;
            dwell    = DWELL_START;
            dir_down = 1'b0;
            take_step();
          end
        end
        EV_UP, EV_DOWN: begin
          if (active) begin
            dir_down = (beat.mode == EV_DOWN);
            result.beep_code = dir_down ? BEEP_DOWN : BEEP_UP;
            dwell = '0;
            take_step();
          end
        end
        EV_STOP: begin
          if (active) begin
            end_scan();
            result.beep_code = BEEP_STOP;
          end
        end
        default: begin
          if (active) begin
            result.beep_code = BEEP_NUL;
          end
        end
      endcase
      result.scan_active = active;
      result.scan_state  = phase;
      expected_q.push_back(result);
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    task check_beat(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected, payload", int'(got), 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.step_cmd !== want.step_cmd) begin
        report("step_cmd", int'(got.step_cmd), int'(want.step_cmd));
      end
      if (got.recall_pulse !== want.recall_pulse) begin
        report("recall_pulse", int'(got.recall_pulse), int'(want.recall_pulse));
      end
      if (got.beep_code !== want.beep_code) begin
        report("beep_code", int'(got.beep_code), int'(want.beep_code));
      end
      if (got.scan_active !== want.scan_active) begin
        report("scan_active", int'(got.scan_active), int'(want.scan_active));
      end
      if (got.scan_state !== want.scan_state) begin
        report("scan_state", int'(got.scan_state), int'(want.scan_state));
      end
    endtask
  endclass

endpackage

/* bench/tb_radio_scan_controller.sv */
// Top-level bench for the radio scan controller: directed and random events.
`timescale 1ns / 1ps

module tb_radio_scan_controller;
  import rsc_pkg::*;
  import scan_scoreboard_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  scan_scoreboard sb;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  radio_scan_controller #(
    .LOST_TIME (LOST_TIME),
    .FIND_TIME (FIND_TIME),
    .SQ_CONFIRM(SQ_CONFIRM)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned stall_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  // Switch between stretches with pauses and stretches without any.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) begin
      quiet <= !quiet;
    end
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= stall_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result beat taken is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_beat(out_data);
    end
  end

  function automatic in_t make_beat(logic [2:0] ev, bit sq, bit chan, bit have, bit rng);
    in_t beat;
    beat.mode              = ev;
    beat.squelch_open      = sq;
    beat.channel_mode      = chan;
    beat.has_scan_channels = have;
    beat.range_ok          = rng;
    return beat;
  endfunction

  // Offers one input beat, with an optional gap first, and waits until it is taken.
  task automatic send_beat(in_t beat);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 99) < 65) ? 0 : stall_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(beat);
  endtask

  // Writes the resume mode once no result is outstanding.
  task automatic write_resume(logic [1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_resume(value);
  endtask

  // Start request, mostly one that the block accepts.
  task automatic send_start();
    bit chan;
    bit good;
    chan = 1'($urandom_range(0, 1));
    good = ($urandom_range(0, 99) < 85);
    if (chan) begin
      send_beat(make_beat(EV_START, 1'($urandom_range(0, 1)), 1'b1, good,
                          1'($urandom_range(0, 1))));
    end else begin
      send_beat(make_beat(EV_START, 1'($urandom_range(0, 1)), 1'b0,
                          1'($urandom_range(0, 1)), good));
    end
  endtask

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned item_count;
    int unsigned body_len;
    int unsigned tick_weight;
    int unsigned pick;
    bit          sq_now;
    logic [2:0]  ev;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no scan running only a start does anything.
    send_beat(make_beat(EV_POLL, 1'b1, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(EV_TICK, 1'b0, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(EV_UP, 1'b1, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(EV_DOWN, 1'b0, 1'b0, 1'b1, 1'b0));
    send_beat(make_beat(EV_STOP, 1'b1, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(EV_UNDEF_A, 1'b0, 1'b0, 1'b0, 1'b0));

    // Refused starts: channel mode without scan channels, VFO mode with a bad range.
    send_beat(make_beat(EV_START, 1'b0, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(EV_START, 1'b0, 1'b0, 1'b1, 1'b0));

    // Accepted start, then a second start and an undefined event, both null beeps.
    send_beat(make_beat(EV_START, 1'b0, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(EV_START, 1'b1, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(EV_UNDEF_B, 1'b1, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(EV_DOWN, 1'b0, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(EV_UP, 1'b0, 1'b0, 1'b0, 1'b0));

    // Squelch confirmed in resume-after-time mode moves to the timed hold.
    repeat (4) send_beat(make_beat(EV_POLL, 1'b1, 1'b0, 1'b0, 1'b0));

    // Carrier during the timed hold in carrier-lost mode reloads the long hold.
    write_resume(RESUME_LOST);
    send_beat(make_beat(EV_POLL, 1'b1, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(EV_STOP, 1'b0, 1'b0, 1'b0, 1'b0));

    // The unused resume mode keeps scanning without a step.
    write_resume(RESUME_NONE);
    send_beat(make_beat(EV_START, 1'b0, 1'b1, 1'b1, 1'b0));
    repeat (4) send_beat(make_beat(EV_POLL, 1'b1, 1'b1, 1'b1, 1'b0));

    // Stop on find: hold, then recall the found channel.
    write_resume(RESUME_FIND);
    send_beat(make_beat(EV_POLL, 1'b1, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(EV_POLL, 1'b0, 1'b0, 1'b0, 1'b0));

    // Random scan sessions with sticky squelch so that holds are reached.
    item_count = 0;
    sq_now = 1'b0;
    while (item_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        write_resume(2'($urandom_range(0, 3)));
      end
      send_start();
      item_count++;
      body_len    = $urandom_range(8, 80);
      tick_weight = $urandom_range(10, 60);
      repeat (body_len) begin
        if ($urandom_range(0, 4) == 0) begin
          sq_now = !sq_now;
        end
        pick = $urandom_range(0, 99);
        if (pick < tick_weight) begin
          ev = EV_TICK;
        end else if (pick < 90) begin
          ev = EV_POLL;
        end else begin
          case (pick)
            90, 91:  ev = EV_UP;
            92, 93:  ev = EV_DOWN;
            94:      ev = EV_START;
            95:      ev = EV_STOP;
            96:      ev = EV_UNDEF_A;
            97:      ev = EV_UNDEF_B;
            default: ev = EV_POLL;
          endcase
        end
        send_beat(make_beat(ev, sq_now, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
        item_count++;
      end
      if ($urandom_range(0, 3) != 0) begin
        send_beat(make_beat(EV_STOP, sq_now, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        item_count++;
      end
    end

    // Let every outstanding result arrive, then watch a little longer.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
